[rtl/va_pkg.sv]
package va_pkg;

  localparam int unsigned FracBitsDef = 16;

  // operation codes
  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_CROSS = 3'd2,
    KIND_DOT   = 3'd3,
    KIND_SCALE = 3'd4,
    KIND_LEN   = 3'd5,
    KIND_UNIT  = 3'd6
  } kind_e;

  // status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  // classified item passed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [2:0][31:0]  rv;
    logic [31:0]       so;
    logic              sat;
    logic [2:0][31:0]  a;
    logic [63:0]       sq;
  } mid_t;

  // finished result
  typedef struct packed {
    logic [2:0][31:0]  rv;
    logic [31:0]       so;
    status_e           status;
  } res_t;

  // clamp to the 32-bit signed range, flag in the top bit
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > 66'sd2147483647) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

[rtl/va_queue.sv]
module va_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  // handshake qualifiers
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

[rtl/va_front.sv]
module va_front #(
  parameter int unsigned FRAC_BITS = va_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [2:0]        kind_i,
  input  logic [2:0][31:0]  a_i,
  input  logic [2:0][31:0]  b_i,
  input  logic [31:0]       s_i,
  output logic              mq_push_o,
  output va_pkg::mid_t      mq_data_o,
  input  logic              mq_full_i
);

  logic                     adv, accept;
  va_pkg::kind_e            kind_in;
  logic signed [31:0]       l_op [6];
  logic signed [31:0]       r_op [6];
  logic                     v1_q, v2_q;
  va_pkg::kind_e            kind1_q;
  logic [2:0][31:0]         a1_q, b1_q;
  logic signed [63:0]       m_q [6];
  va_pkg::mid_t             rec_d, rec_q;
  logic [32:0]              sr;
  logic signed [65:0]       wide;

  assign adv       = !(v2_q && mq_full_i);
  assign full_o    = !adv;
  assign accept    = push_i && adv;
  assign kind_in   = va_pkg::kind_e'(kind_i);
  assign mq_push_o = v2_q && !mq_full_i;
  assign mq_data_o = rec_q;

  // multiplier operand selection
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      l_op[i] = '0;
      r_op[i] = '0;
    end
    case (kind_in)
      va_pkg::KIND_CROSS: begin
        l_op[0] = a_i[1]; r_op[0] = b_i[2];
        l_op[1] = a_i[2]; r_op[1] = b_i[1];
        l_op[2] = a_i[2]; r_op[2] = b_i[0];
        l_op[3] = a_i[0]; r_op[3] = b_i[2];
        l_op[4] = a_i[0]; r_op[4] = b_i[1];
        l_op[5] = a_i[1]; r_op[5] = b_i[0];
      end
      va_pkg::KIND_DOT: begin
        for (int i = 0; i < 3; i++) begin
          l_op[2*i] = a_i[i]; r_op[2*i] = b_i[i];
        end
      end
      va_pkg::KIND_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          l_op[2*i] = a_i[i]; r_op[2*i] = s_i;
        end
      end
      va_pkg::KIND_LEN, va_pkg::KIND_UNIT: begin
        for (int i = 0; i < 3; i++) begin
          l_op[2*i] = a_i[i]; r_op[2*i] = a_i[i];
        end
      end
      default: ;
    endcase
  end

  // combine products and sums into a classified item
  always_comb begin
    rec_d      = '0;
    rec_d.kind = kind1_q;
    sr         = '0;
    wide       = '0;
    case (kind1_q)
      va_pkg::KIND_ADD, va_pkg::KIND_SUB: begin
        for (int i = 0; i < 3; i++) begin
          if (kind1_q == va_pkg::KIND_ADD) begin
            wide = 66'($signed(a1_q[i])) + 66'($signed(b1_q[i]));
          end else begin
            wide = 66'($signed(a1_q[i])) - 66'($signed(b1_q[i]));
          end
          sr = va_pkg::sat32(wide);
          rec_d.rv[i] = sr[31:0];
          rec_d.sat   = rec_d.sat | sr[32];
        end
      end
      va_pkg::KIND_CROSS, va_pkg::KIND_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          wide = (66'(m_q[2*i]) - 66'(m_q[2*i+1])) >>> FRAC_BITS;
          sr = va_pkg::sat32(wide);
          rec_d.rv[i] = sr[31:0];
          rec_d.sat   = rec_d.sat | sr[32];
        end
      end
      va_pkg::KIND_DOT: begin
        wide = (66'(m_q[0]) + 66'(m_q[2]) + 66'(m_q[4])) >>> FRAC_BITS;
        sr = va_pkg::sat32(wide);
        rec_d.so  = sr[31:0];
        rec_d.sat = sr[32];
      end
      va_pkg::KIND_LEN, va_pkg::KIND_UNIT: begin
        rec_d.a  = a1_q;
        rec_d.sq = $unsigned(m_q[0]) + $unsigned(m_q[2]) + $unsigned(m_q[4]);
      end
      default: ;
    endcase
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  // stage payload: products, then classified item
  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind1_q <= kind_in;
      a1_q    <= a_i;
      b1_q    <= b_i;
      for (int i = 0; i < 6; i++) m_q[i] <= l_op[i] * r_op[i];
      rec_q   <= rec_d;
    end
  end

endmodule

[rtl/va_back.sv]
module va_back #(
  parameter int unsigned FRAC_BITS = va_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mq_empty_i,
  input  va_pkg::mid_t  mq_data_i,
  output logic          mq_pop_o,
  output logic          oq_push_o,
  output va_pkg::res_t  oq_data_o,
  input  logic          oq_full_i
);

  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned NST = 33 + FRAC_BITS;

  typedef struct packed {
    va_pkg::mid_t          rec;
    logic [63:0]           v;
    logic [63:0]           r;
    logic [2:0][31:0]      rem;
    logic [2:0][QW-1:0]    q;
  } bk_t;

  logic      adv;
  logic      vld_q [NST];
  bk_t       st_q  [NST];
  bk_t       st_d  [NST];
  bk_t       head;
  bk_t       last;
  logic [31:0] len;

  // one root digit, division setup, or one quotient bit per stage
  function automatic bk_t step(input int unsigned idx, input bk_t s);
    bk_t         o;
    logic [63:0] bit_v, trial;
    logic [31:0] ln, mag;
    logic [32:0] rem2;
    o = s;
    bit_v = '0;
    trial = '0;
    ln = s.r[31:0];
    mag = '0;
    rem2 = '0;
    if (idx < 32) begin
      bit_v = 64'd1 << (62 - 2 * idx);
      trial = s.r + bit_v;
      if (s.v >= trial) begin
        o.v = s.v - trial;
        o.r = (s.r >> 1) + bit_v;
      end else begin
        o.r = s.r >> 1;
      end
    end else if (idx == 32) begin
      for (int i = 0; i < 3; i++) begin
        mag = s.rec.a[i][31] ? (-s.rec.a[i]) : s.rec.a[i];
        o.q[i] = '0;
        if (mag >= ln) begin
          o.rem[i] = mag - ln;
          o.q[i][0] = 1'b1;
        end else begin
          o.rem[i] = mag;
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        rem2 = {s.rem[i], 1'b0};
        if (rem2 >= {1'b0, ln}) begin
          o.rem[i] = 32'(rem2 - {1'b0, ln});
          o.q[i] = {s.q[i][QW-2:0], 1'b1};
        end else begin
          o.rem[i] = rem2[31:0];
          o.q[i] = {s.q[i][QW-2:0], 1'b0};
        end
      end
    end
    return o;
  endfunction

  assign adv       = !(vld_q[NST-1] && oq_full_i);
  assign mq_pop_o  = adv && !mq_empty_i;
  assign oq_push_o = adv && vld_q[NST-1];

  // pipeline entry
  always_comb begin
    head     = '0;
    head.rec = mq_data_i;
    head.v   = mq_data_i.sq;
  end

  // stage logic
  for (genvar g = 0; g < NST; g++) begin : g_st
    if (g == 0) begin : g_first
      assign st_d[g] = step(g, head);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[g] <= 1'b0;
        end else if (adv) begin
          vld_q[g] <= !mq_empty_i;
        end
      end
    end else begin : g_rest
      assign st_d[g] = step(g, st_q[g-1]);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[g] <= 1'b0;
        end else if (adv) begin
          vld_q[g] <= vld_q[g-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) st_q[g] <= st_d[g];
    end
  end

  // result assembly
  assign last = st_q[NST-1];
  assign len  = last.r[31:0];

  always_comb begin
    oq_data_o        = '0;
    oq_data_o.rv     = last.rec.rv;
    oq_data_o.so     = last.rec.so;
    oq_data_o.status = last.rec.sat ? va_pkg::ST_SAT : va_pkg::ST_OK;
    case (last.rec.kind)
      va_pkg::KIND_LEN: begin
        if (len[31]) begin
          oq_data_o.so     = 32'h7FFF_FFFF;
          oq_data_o.status = va_pkg::ST_SAT;
        end else begin
          oq_data_o.so = len;
        end
      end
      va_pkg::KIND_UNIT: begin
        if (len == '0) begin
          oq_data_o.status = va_pkg::ST_ZERO;
        end else begin
          for (int i = 0; i < 3; i++) begin
            oq_data_o.rv[i] = last.rec.a[i][31] ? (-32'(last.q[i])) : 32'(last.q[i]);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/vector3_alu.sv]
// the result path runs through the 32-stage square root and the FRAC_BITS + 1
// stage divider lanes; values are Q16.16 at the default FRAC_BITS
// throughput: one beat per cycle when not full; every op takes the same pipeline
// reset: asynchronous, active low; clears all queues and stage valids, no state kept
module vector3_alu #(
  parameter int unsigned FRAC_BITS = va_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind_i,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] a_z_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [31:0] b_z_i,
  input  logic [31:0] scalar_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] r_x_o,
  output logic [31:0] r_y_o,
  output logic [31:0] r_z_o,
  output logic [31:0] scalar_out_o,
  output logic [1:0]  status_o
);

  localparam int unsigned MidW = $bits(va_pkg::mid_t);
  localparam int unsigned ResW = $bits(va_pkg::res_t);

  logic          mq_push, mq_full, mq_empty, mq_pop;
  va_pkg::mid_t  mq_wdata, mq_rdata;
  logic [MidW-1:0] mq_rbits;
  logic          oq_push, oq_full;
  va_pkg::res_t  oq_wdata, oq_rdata;
  logic [ResW-1:0] oq_rbits;

  // front: accept, multiply, classify
  va_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .kind_i    (kind_i),
    .a_i       ({a_z_i, a_y_i, a_x_i}),
    .b_i       ({b_z_i, b_y_i, b_x_i}),
    .s_i       (scalar_in_i),
    .mq_push_o (mq_push),
    .mq_data_o (mq_wdata),
    .mq_full_i (mq_full)
  );

  // queue between front and back
  va_queue #(.WIDTH(MidW)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .wdata_i (mq_wdata),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .rdata_o (mq_rbits),
    .empty_o (mq_empty)
  );
  assign mq_rdata = va_pkg::mid_t'(mq_rbits);

  // back: root, divide, finish
  va_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mq_empty_i (mq_empty),
    .mq_data_i  (mq_rdata),
    .mq_pop_o   (mq_pop),
    .oq_push_o  (oq_push),
    .oq_data_o  (oq_wdata),
    .oq_full_i  (oq_full)
  );

  // result queue
  va_queue #(.WIDTH(ResW)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .wdata_i (oq_wdata),
    .full_o  (oq_full),
    .pop_i   (pop),
    .rdata_o (oq_rbits),
    .empty_o (empty)
  );
  assign oq_rdata = va_pkg::res_t'(oq_rbits);

  // result ports
  assign r_x_o        = oq_rdata.rv[0];
  assign r_y_o        = oq_rdata.rv[1];
  assign r_z_o        = oq_rdata.rv[2];
  assign scalar_out_o = oq_rdata.so;
  assign status_o     = oq_rdata.status;

endmodule

[tb/vector3_alu_test.sv]
module vector3_alu_test;

  localparam int unsigned Frac = va_pkg::FracBitsDef;
  localparam logic [2:0] KindUnused = 3'd7;
  localparam int unsigned StallLimit = 5000;
  localparam logic [31:0] WordMax = 32'h7FFF_FFFF;
  localparam logic [31:0] WordMin = 32'h8000_0000;
  localparam logic [31:0] One = 32'h0001_0000;

  // one operand beat
  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      s;
  } vec_op_t;

  // one result beat
  typedef struct packed {
    logic [2:0][31:0] r;
    logic [31:0]      so;
    va_pkg::status_e  st;
  } vec_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  kind_i = '0;
  logic [31:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic [31:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic [31:0] scalar_in_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] r_x_o, r_y_o, r_z_o, scalar_out_o;
  logic [1:0]  status_o;

  vec_res_t    pending_results[$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          hold_cycles = 0;
  int          pop_gap = 0;
  int          stall_count = 0;

  vector3_alu dut (
    .clk_i, .rst_ni, .push, .full, .kind_i,
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i, .scalar_in_i,
    .empty, .pop, .r_x_o, .r_y_o, .r_z_o, .scalar_out_o, .status_o
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // clamp to 32-bit signed
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return WordMax;
    end else if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return WordMin;
    end
    return v[31:0];
  endfunction

  // floor square root, bit by bit
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r, one_bit, rem;
    r = '0;
    rem = v;
    one_bit = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (rem >= r + one_bit) begin
        rem = rem - (r + one_bit);
        r = (r >> 1) + one_bit;
      end else begin
        r = r >> 1;
      end
      one_bit = one_bit >> 2;
    end
    return r;
  endfunction

  // expected result of one operation
  function automatic vec_res_t vector_math(input vec_op_t op);
    vec_res_t res;
    logic signed [127:0] av[3], bv[3], sv, acc;
    logic [63:0] sq, len, mag, q;
    bit sat;
    int j, k;
    res = '0;
    sat = 1'b0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      av[i] = $signed(op.a[i]);
      bv[i] = $signed(op.b[i]);
    end
    sv = $signed(op.s);
    case (op.kind)
      va_pkg::KIND_ADD: for (int i = 0; i < 3; i++) res.r[i] = clamp32(av[i] + bv[i], sat);
      va_pkg::KIND_SUB: for (int i = 0; i < 3; i++) res.r[i] = clamp32(av[i] - bv[i], sat);
      va_pkg::KIND_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          acc = av[j] * bv[k] - av[k] * bv[j];
          res.r[i] = clamp32(acc >>> Frac, sat);
        end
      end
      va_pkg::KIND_DOT: begin
        acc = av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2];
        res.so = clamp32(acc >>> Frac, sat);
      end
      va_pkg::KIND_SCALE: begin
        for (int i = 0; i < 3; i++) res.r[i] = clamp32((av[i] * sv) >>> Frac, sat);
      end
      va_pkg::KIND_LEN, va_pkg::KIND_UNIT: begin
        for (int i = 0; i < 3; i++) begin
          acc = av[i] * av[i];
          sq = sq + acc[63:0];
        end
        len = floor_root(sq);
        if (op.kind == va_pkg::KIND_LEN) begin
          res.so = clamp32($signed({64'd0, len}), sat);
        end else if (len == 0) begin
          res.st = va_pkg::ST_ZERO;
        end else begin
          for (int i = 0; i < 3; i++) begin
            acc = (av[i] < 0) ? -av[i] : av[i];
            mag = acc[63:0];
            q = (mag << Frac) / len;
            acc = $signed({64'd0, q});
            res.r[i] = clamp32((av[i] < 0) ? -acc : acc, sat);
          end
        end
      end
      default: ;
    endcase
    if (sat && res.st == va_pkg::ST_OK) res.st = va_pkg::ST_SAT;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", field, got, want);
  endtask

  // send one beat, wait for it to be taken
  task automatic send_op(input vec_op_t op);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        push = 1'b0;
      end
    end
    @(negedge clk_i);
    push = 1'b1;
    kind_i = op.kind;
    {a_z_i, a_y_i, a_x_i} = op.a;
    {b_z_i, b_y_i, b_x_i} = op.b;
    scalar_in_i = op.s;
    do @(posedge clk_i); while (full);
    pending_results.insert(pending_results.size(), vector_math(op));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return WordMax;
          2: return WordMin;
          3: return 32'hFFFF_FFFF;
          4: return One;
          default: return -One;
        endcase
      end
    endcase
  endfunction

  function automatic vec_op_t rand_op();
    vec_op_t op;
    op.kind = ($urandom_range(0, 39) == 0) ? KindUnused : 3'($urandom_range(0, 6));
    for (int i = 0; i < 3; i++) begin
      op.a[i] = rand_word();
      op.b[i] = rand_word();
    end
    op.s = rand_word();
    // some zero-length vectors for the unit operation
    if (op.kind == va_pkg::KIND_UNIT && $urandom_range(0, 9) == 0) op.a = '0;
    return op;
  endfunction

  function automatic vec_op_t mk(input logic [2:0] kd, input logic [31:0] ax,
      input logic [31:0] ay, input logic [31:0] az, input logic [31:0] bx,
      input logic [31:0] by, input logic [31:0] bz, input logic [31:0] s);
    vec_op_t op;
    op.kind = kd;
    op.a = {az, ay, ax};
    op.b = {bz, by, bx};
    op.s = s;
    return op;
  endfunction

  // result checker and receiver idling
  initial begin
    vec_res_t want;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", r_x_o, '0);
        end else begin
          want = pending_results.pop_front();
          if (r_x_o !== want.r[0]) report_mismatch("r_x", r_x_o, want.r[0]);
          if (r_y_o !== want.r[1]) report_mismatch("r_y", r_y_o, want.r[1]);
          if (r_z_o !== want.r[2]) report_mismatch("r_z", r_z_o, want.r[2]);
          if (scalar_out_o !== want.so) report_mismatch("scalar_out", scalar_out_o, want.so);
          if (status_o !== want.st) report_mismatch("status", 32'(status_o), 32'(want.st));
        end
      end
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop = 1'b0;
      end else if (!quiet && pop_gap > 0) begin
        pop_gap--;
        pop = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(1, 6) - 1;
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat moving
  initial begin
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) stall_count = 0;
      else stall_count++;
      if (stall_count >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_op(mk(va_pkg::KIND_ADD, WordMax, WordMin, One, WordMax, WordMin, -One, '0));
    send_op(mk(va_pkg::KIND_ADD, 32'd5, -32'd7, '0, 32'd3, 32'd2, '0, '0));
    send_op(mk(va_pkg::KIND_SUB, WordMin, WordMax, '0, WordMax, WordMin, '0, '0));
    send_op(mk(va_pkg::KIND_SUB, One, One, One, One, -One, 32'd1, '0));
    send_op(mk(va_pkg::KIND_CROSS, One, '0, '0, '0, One, '0, '0));
    send_op(mk(va_pkg::KIND_CROSS, WordMin, WordMax, WordMin, WordMax, WordMin, WordMin,
               '0));
    send_op(mk(va_pkg::KIND_CROSS, -32'd1, 32'd3, 32'd1, 32'd1, -32'd1, 32'd2, '0));
    send_op(mk(va_pkg::KIND_DOT, WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, '0));
    send_op(mk(va_pkg::KIND_DOT, WordMax, WordMin, '0, WordMin, WordMax, '0, '0));
    send_op(mk(va_pkg::KIND_DOT, -32'd1, 32'd1, '0, 32'd1, 32'd1, '0, '0));
    send_op(mk(va_pkg::KIND_SCALE, One, -One, WordMax, '0, '0, '0, One));
    send_op(mk(va_pkg::KIND_SCALE, WordMax, WordMin, -32'd1, '0, '0, '0, WordMax));
    send_op(mk(va_pkg::KIND_SCALE, WordMin, 32'd3, -32'd3, '0, '0, '0, WordMin));
    send_op(mk(va_pkg::KIND_LEN, '0, '0, '0, '0, '0, '0, '0));
    send_op(mk(va_pkg::KIND_LEN, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0));
    send_op(mk(va_pkg::KIND_LEN, WordMin, WordMin, WordMin, '0, '0, '0, '0));
    send_op(mk(va_pkg::KIND_LEN, WordMax, '0, '0, '0, '0, '0, '0));
    send_op(mk(va_pkg::KIND_UNIT, '0, '0, '0, One, One, One, One));
    send_op(mk(va_pkg::KIND_UNIT, One, '0, '0, '0, '0, '0, '0));
    send_op(mk(va_pkg::KIND_UNIT, WordMin, WordMax, 32'd1, '0, '0, '0, '0));
    send_op(mk(va_pkg::KIND_UNIT, '0, '0, -32'd1, '0, '0, '0, '0));
    send_op(mk(KindUnused, WordMax, WordMin, One, WordMax, WordMin, One, WordMax));
    stop_sending();
  endtask

  task automatic test_random_ops(input int n);
    repeat (n) send_op(rand_op());
    stop_sending();
  endtask

  // receiver holds off while the sender keeps going
  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (250) send_op(rand_op());
    stop_sending();
  endtask

  // sender waits for every result before going on
  task automatic test_drain_pause();
    repeat (50) send_op(rand_op());
    stop_sending();
    wait_drained();
    repeat (200) send_op(rand_op());
    stop_sending();
  endtask

  task automatic test_streaming();
    quiet = 1'b1;
    repeat (300) send_op(rand_op());
    stop_sending();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_ops(700);
    test_backpressure();
    test_drain_pause();
    test_streaming();
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
